>>> hdl/frc_pkg.sv
// Package: payload types, codes and defaults of the frustum ray clip distance unit.
`timescale 1ns / 1ps
`default_nettype none
package frc_pkg;

  localparam int NUM_PLANES_DEF = 6;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CFG_AW         = 3;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_INSIDE = 2'd0,
    OUT_HIT    = 2'd1,
    OUT_MISS   = 2'd2
  } outcome_e;

  typedef enum logic {
    REG_INSIDE_EPS   = 1'b0,
    REG_PARALLEL_EPS = 1'b1
  } reg_e;

  typedef struct packed {
    logic               command;
    logic        [2:0]  plane_index;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] plane_offset;
    logic signed [31:0] ray_pos_x;
    logic signed [31:0] ray_pos_y;
    logic signed [31:0] ray_pos_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
  } frc_req_t;

  typedef struct packed {
    logic [30:0] hit_distance;
    logic [1:0]  outcome;
  } frc_rsp_t;

  typedef struct packed {
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic signed [31:0] offs;
  } plane_t;

endpackage
`default_nettype wire

>>> hdl/frc_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface frc_req_if;
  logic              valid;
  logic              ready;
  frc_pkg::frc_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface frc_rsp_if;
  logic              valid;
  logic              ready;
  frc_pkg::frc_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/frustum_ray_clip_distance_unit.sv
// Top level: plane store, shared multiplier and serial divider clipping rays against the frustum.
//
// channel  | role   | beat carries
// req_i    | sink   | load plane or query ray
// rsp_o    | source | hit_distance, outcome (one per query)
// apb      | slave  | inside_epsilon, parallel_epsilon
//
// A load is taken in the idle state. A query reads each plane from the store, runs six
// products on the shared multiplier, drains it and evaluates, plane by plane, for the inside
// test; clipping adds 32 divider steps and an update per plane (the steps are skipped when
// the quotient saturates, the update too when parallel), then the finish state hands over.
// No clearing pass after reset; the store is undefined until written.
// A finished result waits in the output register; a new beat is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module frustum_ray_clip_distance_unit #(
  parameter int NUM_PLANES = frc_pkg::NUM_PLANES_DEF,
  parameter int FRAC_BITS  = frc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  frc_req_if.sink                        req_i,
  frc_rsp_if.source                      rsp_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [frc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready
);
  import frc_pkg::*;

  localparam int PA = $clog2(NUM_PLANES);
  localparam int NW = 64 + FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DRAIN = 8'b0000_1000,
    S_EVAL  = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_UPD   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  plane_t mem [NUM_PLANES];
  plane_t rd_q;

  logic [15:0] ieps_q, peps_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] dir_q [3];
  logic [PA-1:0] plane_q;
  logic          phase_q;
  logic [2:0]    cnt_q;
  logic signed [63:0] prod_q;
  logic          prodv_q, prodsel_q;
  logic signed [63:0] db_q, da_q;
  logic signed [31:0] tmin_q, tmax_q;
  logic [NW-1:0] r_q;
  logic [95:0]   dsh_q;
  logic [31:0]   q_q;
  logic [4:0]    dcnt_q;
  logic          neg_q;
  logic [30:0]   fdist_q;
  outcome_e      fout_q;
  logic          out_v_q;
  frc_rsp_t      out_q;

  logic accept, cfg_we, last_plane;
  assign accept     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_we     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign last_plane = (plane_q == PA'(NUM_PLANES - 1));

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_INSIDE_EPS:   prdata = {16'b0, ieps_q};
      REG_PARALLEL_EPS: prdata = {16'b0, peps_q};
      default:          prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ieps_q <= 16'd1;
      peps_q <= 16'd1;
    end else if (cfg_we) begin
      case (reg_e'(paddr[2]))
        REG_INSIDE_EPS:   ieps_q <= pwdata[15:0];
        REG_PARALLEL_EPS: peps_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.data.command == CMD_LOAD &&
        int'(req_i.data.plane_index) < NUM_PLANES) begin
      mem[PA'(req_i.data.plane_index)] <= '{nrm_x: req_i.data.normal_x,
                                            nrm_y: req_i.data.normal_y,
                                            nrm_z: req_i.data.normal_z,
                                            offs:  req_i.data.plane_offset};
    end
    rd_q <= mem[plane_q];
  end

  logic signed [31:0] mul_a, mul_b;
  always_comb begin
    case (cnt_q)
      3'd0: begin mul_a = rd_q.nrm_x; mul_b = pos_q[0]; end
      3'd1: begin mul_a = rd_q.nrm_y; mul_b = pos_q[1]; end
      3'd2: begin mul_a = rd_q.nrm_z; mul_b = pos_q[2]; end
      3'd3: begin mul_a = rd_q.nrm_x; mul_b = dir_q[0]; end
      3'd4: begin mul_a = rd_q.nrm_y; mul_b = dir_q[1]; end
      3'd5: begin mul_a = rd_q.nrm_z; mul_b = dir_q[2]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  logic signed [63:0] prod_sh, mag;
  logic [63:0]  un, ud;
  logic         par, ovf, dneg, ge;
  logic [31:0]  limit, qc;
  logic signed [32:0] t33;
  logic signed [31:0] t, res;
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign mag     = da_q[63] ? -da_q : da_q;
  assign par     = (da_q == 64'sd0) || (mag < $signed({48'b0, peps_q}));
  assign un      = db_q > 64'sd0 ? 64'(db_q) : 64'(-db_q);
  assign ud      = 64'(mag);
  assign dneg    = ((db_q > 64'sd0) != da_q[63]) && (db_q != 64'sd0);
  assign ovf     = {(97 - NW)'(0), un, FRAC_BITS'(0)} >= {1'b0, ud, 32'b0};
  assign ge      = {(96 - NW)'(0), r_q} >= dsh_q;
  assign limit   = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
  assign qc      = (q_q > limit) ? limit : q_q;
  assign t33     = neg_q ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  assign t       = t33[31:0];
  assign res     = tmin_q[31] ? tmax_q : tmin_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept && req_i.data.command == CMD_QUERY) state_d = S_READ;
      S_READ:  state_d = S_MUL;
      S_MUL:   if (cnt_q == 3'd5) state_d = S_DRAIN;
      S_DRAIN: state_d = S_EVAL;
      S_EVAL: begin
        if (!phase_q) begin
          if (db_q > $signed({48'b0, ieps_q})) state_d = S_READ;
          else if (last_plane) state_d = S_FIN;
          else state_d = S_READ;
        end else if (par) begin
          if (db_q > 64'sd0 || last_plane) state_d = S_FIN;
          else state_d = S_READ;
        end else begin
          state_d = ovf ? S_UPD : S_DIV;
        end
      end
      S_DIV:   if (dcnt_q == 5'd31) state_d = S_UPD;
      S_UPD: begin
        if ((da_q[63] && t > tmax_q) || (!da_q[63] && t < tmin_q) || last_plane)
          state_d = S_FIN;
        else state_d = S_READ;
      end
      S_FIN:   if (!out_v_q || rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      prodv_q <= 1'b0;
      cnt_q   <= '0;
      dcnt_q  <= '0;
      plane_q <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && (!out_v_q || rsp_o.ready)) out_v_q <= 1'b1;
      else if (rsp_o.ready) out_v_q <= 1'b0;
      prodv_q <= (state_q == S_MUL);
      case (state_q)
        S_IDLE: begin
          plane_q <= '0;
          phase_q <= 1'b0;
        end
        S_READ: cnt_q <= '0;
        S_MUL:  cnt_q <= cnt_q + 3'd1;
        S_EVAL: begin
          dcnt_q <= '0;
          if (!phase_q) begin
            if (db_q > $signed({48'b0, ieps_q})) begin
              phase_q <= 1'b1;
              plane_q <= '0;
            end else if (!last_plane) plane_q <= plane_q + PA'(1);
          end else if (par && !last_plane) plane_q <= plane_q + PA'(1);
        end
        S_DIV:  dcnt_q <= dcnt_q + 5'd1;
        S_UPD:  if (!last_plane) plane_q <= plane_q + PA'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= mul_a * mul_b;
    prodsel_q <= (cnt_q > 3'd2);
    if (prodv_q) begin
      if (prodsel_q) da_q <= da_q + prod_sh;
      else db_q <= db_q + prod_sh;
    end
    case (state_q)
      S_IDLE: begin
        pos_q[0] <= req_i.data.ray_pos_x;
        pos_q[1] <= req_i.data.ray_pos_y;
        pos_q[2] <= req_i.data.ray_pos_z;
        dir_q[0] <= req_i.data.ray_dir_x;
        dir_q[1] <= req_i.data.ray_dir_y;
        dir_q[2] <= req_i.data.ray_dir_z;
      end
      S_MUL: begin
        if (cnt_q == 3'd0) begin
          db_q <= 64'(rd_q.offs);
          da_q <= '0;
        end
      end
      S_EVAL: begin
        neg_q <= dneg;
        q_q   <= '1;
        r_q   <= {un, FRAC_BITS'(0)};
        dsh_q <= {1'b0, ud, 31'b0};
        if (!phase_q) begin
          tmin_q  <= 32'sh8000_0000;
          tmax_q  <= 32'sh7fff_ffff;
          fdist_q <= '0;
          fout_q  <= OUT_INSIDE;
        end else if (par) begin
          if (db_q > 64'sd0) begin
            fdist_q <= '0;
            fout_q  <= OUT_MISS;
          end else if (last_plane) begin
            fdist_q <= res[30:0];
            fout_q  <= res[31] ? OUT_MISS : OUT_HIT;
            if (res[31]) fdist_q <= '0;
          end
        end
      end
      S_DIV: begin
        if (ge) r_q <= r_q - dsh_q[NW-1:0];
        q_q   <= {q_q[30:0], ge};
        dsh_q <= dsh_q >> 1;
      end
      S_UPD: begin
        logic signed [31:0] nmin, nmax, nres;
        nmin = tmin_q;
        nmax = tmax_q;
        if (da_q[63]) begin
          if (t > tmin_q) nmin = t;
        end else if (t < tmax_q) nmax = t;
        nres = nmin[31] ? nmax : nmin;
        tmin_q <= nmin;
        tmax_q <= nmax;
        if ((da_q[63] && t > tmax_q) || (!da_q[63] && t < tmin_q) || nres[31]) begin
          fdist_q <= '0;
          fout_q  <= OUT_MISS;
        end else begin
          fdist_q <= nres[30:0];
          fout_q  <= OUT_HIT;
        end
      end
      S_FIN: if (!out_v_q || rsp_o.ready) out_q <= '{hit_distance: fdist_q, outcome: fout_q};
      default: ;
    endcase
  end

  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;

`ifndef ASSERT_OFF
  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q == S_FIN))
    else $error("result shown without finishing a query");
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.outcome == OUT_INSIDE || out_q.outcome == OUT_HIT ||
                 out_q.outcome == OUT_MISS))
    else $error("bad outcome code");
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.outcome != OUT_HIT) |-> (out_q.hit_distance == '0))
    else $error("nonzero distance on inside or miss");
  a_div_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |=> (state_q == S_DIV || state_q == S_UPD))
    else $error("divider left early");
`endif

endmodule
`default_nettype wire

>>> verif/frustum_ray_clip_distance_unit_tb.sv
// Testbench: frustum ray clip distance unit, random and directed plane loads and ray queries.
`timescale 1ns / 1ps
module frustum_ray_clip_distance_unit_tb;
  import frc_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = 64'sd65536;

  class clip_scoreboard;
    longint   pn_x[NUM_PLANES_DEF], pn_y[NUM_PLANES_DEF], pn_z[NUM_PLANES_DEF];
    longint   p_off[NUM_PLANES_DEF];
    longint   in_eps = 1, par_eps = 1;
    frc_rsp_t expected_hits[$];
    int       errors = 0;

    function void set_reg(reg_e r, logic [15:0] v);
      if (r == REG_INSIDE_EPS) in_eps = v;
      else par_eps = v;
    endfunction

    function longint mulq(longint a, longint b);
      return (a * b) >>> FB;
    endfunction

    function longint side(int i, longint x, longint y, longint z);
      return mulq(pn_x[i], x) + mulq(pn_y[i], y) + mulq(pn_z[i], z);
    endfunction

    function longint divq(longint num, longint den);
      longint unsigned un, ud, q, rem, lim;
      bit neg;
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      neg = ((num < 0) != (den < 0)) && un != 0;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      q = un / ud;
      rem = un % ud;
      if (q > (lim >> FB)) q = lim;
      else begin
        for (int k = 0; k < FB; k++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= ud) begin
            rem = rem - ud;
            q = q | 1;
          end
        end
        if (q > lim) q = lim;
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function frc_rsp_t clip_ray(frc_req_t r);
      frc_rsp_t o;
      longint px, py, pz, dx, dy, dz, da, db, mag, t, t_in, t_out, res;
      bit org_in;
      px = r.ray_pos_x; py = r.ray_pos_y; pz = r.ray_pos_z;
      dx = r.ray_dir_x; dy = r.ray_dir_y; dz = r.ray_dir_z;
      org_in = 1;
      for (int i = 0; i < NUM_PLANES_DEF; i++)
        if (side(i, px, py, pz) + p_off[i] > in_eps) org_in = 0;
      o.hit_distance = '0;
      o.outcome = OUT_INSIDE;
      if (org_in) return o;
      o.outcome = OUT_MISS;
      t_in = -64'sd2147483648;
      t_out = 64'sd2147483647;
      for (int i = 0; i < NUM_PLANES_DEF; i++) begin
        da = side(i, dx, dy, dz);
        db = side(i, px, py, pz) + p_off[i];
        mag = da < 0 ? -da : da;
        if (da == 0 || mag < par_eps) begin
          if (db > 0) return o;
        end else begin
          t = divq(-db, da);
          if (da < 0) begin
            if (t > t_out) return o;
            if (t > t_in) t_in = t;
          end else begin
            if (t < t_in) return o;
            if (t < t_out) t_out = t;
          end
        end
      end
      res = t_in >= 0 ? t_in : t_out;
      if (res < 0) return o;
      o.hit_distance = res[30:0];
      o.outcome = OUT_HIT;
      return o;
    endfunction

    function void note_beat(frc_req_t r);
      if (r.command == CMD_QUERY) expected_hits.push_back(clip_ray(r));
      else if (r.plane_index < NUM_PLANES_DEF) begin
        pn_x[r.plane_index] = r.normal_x;
        pn_y[r.plane_index] = r.normal_y;
        pn_z[r.plane_index] = r.normal_z;
        p_off[r.plane_index] = r.plane_offset;
      end
    endfunction

    function void check_beat(frc_rsp_t a);
      frc_rsp_t e;
      if (expected_hits.size() == 0) begin
        $error("unexpected result beat: hit_distance %0d outcome %0d", a.hit_distance, a.outcome);
        errors++;
        return;
      end
      e = expected_hits.pop_front();
      if (a.hit_distance !== e.hit_distance) begin
        $error("hit_distance: expected %0d, got %0d", e.hit_distance, a.hit_distance);
        errors++;
      end
      if (a.outcome !== e.outcome) begin
        $error("outcome: expected %0d, got %0d", e.outcome, a.outcome);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  bit   hold_rsp = 0;
  bit   calm = 0;

  frc_req_if req ();
  frc_rsp_if rsp ();
  clip_scoreboard sb = new();

  frustum_ray_clip_distance_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    req.valid = 0;
    req.data = '0;
    rsp.ready = 0;
  end

  function int pick_gap();
    int c;
    if (calm) return 0;
    c = $urandom_range(0, 99);
    if (c < 70) return 0;
    if (c < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && req.valid && req.ready) sb.note_beat(req.data);
    if (rst_ni && rsp.valid && rsp.ready) sb.check_beat(rsp.data);
  end

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp.ready <= 0;
        repeat (1500) @(posedge clk_i);
        hold_rsp = 0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          rsp.ready <= 0;
          repeat (g) @(posedge clk_i);
        end
        rsp.ready <= 1;
      end
    end
  end

  task automatic send(frc_req_t r);
    int g;
    req.valid <= 1;
    req.data <= r;
    do @(posedge clk_i); while (!req.ready);
    g = pick_gap();
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain(int extra);
    req.valid <= 0;
    @(posedge clk_i);
    while (sb.expected_hits.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [15:0] v);
    @(posedge clk_i);
    psel <= 1;
    pwrite <= 1;
    paddr <= {r, 2'b00};
    pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(r, v);
  endtask

  function frc_req_t noise();
    logic [383:0] b;
    b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom};
    return b[$bits(frc_req_t)-1:0];
  endfunction

  function frc_req_t load_plane(int idx, longint x, longint y, longint z, longint d);
    frc_req_t r;
    r = noise();
    r.command = CMD_LOAD;
    r.plane_index = 3'(idx);
    r.normal_x = 32'(x); r.normal_y = 32'(y); r.normal_z = 32'(z);
    r.plane_offset = 32'(d);
    return r;
  endfunction

  function frc_req_t ray(longint px, longint py, longint pz,
                         longint dx, longint dy, longint dz);
    frc_req_t r;
    r = noise();
    r.command = CMD_QUERY;
    r.ray_pos_x = 32'(px); r.ray_pos_y = 32'(py); r.ray_pos_z = 32'(pz);
    r.ray_dir_x = 32'(dx); r.ray_dir_y = 32'(dy); r.ray_dir_z = 32'(dz);
    return r;
  endfunction

  function longint sq(int lim_units);
    return longint'($urandom_range(0, 2 * lim_units * 65536)) - longint'(lim_units) * 65536;
  endfunction

  task automatic load_box();
    send(load_plane(0, ONE, 0, 0, -ONE));
    send(load_plane(1, -ONE, 0, 0, -ONE));
    send(load_plane(2, 0, ONE, 0, -ONE));
    send(load_plane(3, 0, -ONE, 0, -ONE));
    send(load_plane(4, 0, 0, ONE, -ONE));
    send(load_plane(5, 0, 0, -ONE, -2 * ONE));
  endtask

  task automatic load_frustum();
    for (int i = 0; i < NUM_PLANES_DEF; i++) begin
      if ($urandom_range(0, 9) == 0) send(noise());
      else send(load_plane(i, sq(2), sq(2), sq(2), -longint'($urandom_range(0, 8 * 65536))));
    end
  endtask

  task automatic random_item();
    int c;
    frc_req_t r;
    c = $urandom_range(0, 99);
    if (c < 8) begin
      r = noise();
      r.command = CMD_QUERY;
      send(r);
    end else if (c < 12) begin
      r = noise();
      r.command = CMD_LOAD;
      r.plane_index = 3'($urandom_range(6, 7));
      send(r);
    end else if (c < 16) begin
      send(load_plane($urandom_range(0, 5), sq(2), sq(2), sq(2), sq(4)));
    end else if (c < 26) begin
      send(ray(sq(1), sq(1), sq(1), sq(2), sq(2), sq(2)));
    end else begin
      send(ray(sq(10), sq(10), sq(10), sq(2), sq(2), sq(2)));
    end
  endtask

  initial begin
    frc_req_t r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    write_reg(REG_INSIDE_EPS, 16'd1);
    write_reg(REG_PARALLEL_EPS, 16'd1);

    load_box();
    send(ray(0, 0, 0, ONE, 0, 0));
    send(ray(5 * ONE, 0, 0, -ONE, 0, 0));
    send(ray(5 * ONE, 0, 0, 0, ONE, 0));
    send(ray(5 * ONE, 0, 0, ONE, 0, 0));
    send(ray(5 * ONE, 0, 0, 0, 0, 0));
    send(ray(5 * ONE, 0, 0, -1, 0, 0));
    send(ray(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
             32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send(ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
             -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000));
    send(ray(ONE + 1, 0, 0, -ONE, 0, 0));
    send(ray(5 * ONE, 5 * ONE, 0, -ONE, ONE, 0));
    r = noise();
    r.command = CMD_LOAD;
    r.plane_index = 3'd6;
    send(r);
    r.plane_index = 3'd7;
    send(r);
    send(load_plane(5, 32'sh7fff_ffff, -32'sh8000_0000, 32'sh7fff_ffff, -32'sh8000_0000));
    send(ray(ONE, ONE, ONE, ONE, -ONE, 0));
    send(ray(0, 0, 0, 0, 0, 0));
    drain(20);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_INSIDE_EPS, 16'd0);
          write_reg(REG_PARALLEL_EPS, 16'd0);
        end
        1: begin
          write_reg(REG_INSIDE_EPS, 16'hffff);
          write_reg(REG_PARALLEL_EPS, 16'hffff);
        end
        default: begin
          write_reg(REG_INSIDE_EPS, 16'($urandom_range(0, 65535)));
          write_reg(REG_PARALLEL_EPS, 16'($urandom_range(0, 4000)));
        end
      endcase
      if (ph % 2 == 0) load_box();
      else load_frustum();
      for (int n = 0; n < 150; n++) begin
        if (n % 50 == 0) calm = $urandom_range(0, 1);
        if (ph == 2 && n == 20) hold_rsp = 1;
        if (ph == 3 && n == 75) drain(0);
        if (n % 40 == 39) load_frustum();
        random_item();
      end
      calm = 0;
      req.valid <= 0;
      drain(20);
    end

    drain(100);
    if (sb.errors == 0 && sb.expected_hits.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

>>> sim.f
hdl/frc_pkg.sv
hdl/frc_if.sv
hdl/frustum_ray_clip_distance_unit.sv
verif/frustum_ray_clip_distance_unit_tb.sv
